[sv/olid_pkg.sv]
// Shared types and constants for the ordered list block.
// Used by olid_store, olid_ctrl, the top level and the checker.
package olid_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int ODATA_W = 40;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DEL_HEAD = 2'd1,
    MODE_DEL_KEY  = 2'd2,
    MODE_DEL_TAIL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;
    logic [IDX_W-1:0]        raddr;
  } mem_req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage

[sv/ordered_list_insert_delete.sv]
// Top level of the ordered list block: stream ports, sequencer, entry
// store and output register. Depends on olid_pkg, olid_ctrl, olid_store.
//
//   channel  dir  tdata                               tuser
//   in_      in   [31:0] value                        [1:0] mode
//   out_     out  [31:0] removed_value, [36:32] count [1:0] status
//
// One request at a time. Insert, empty and full replies need no store read.
// Delete head or tail: one read. Delete by value: one read per entry
// searched plus a read and a write per entry moved, and searched plus moved
// is the count, all through the single read port.
// Synchronous active-low reset empties the list; no clearing pass.
// A held result stalls the sequencer in its final state only.
module ordered_list_insert_delete (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] value
  input  logic [1:0]                    in_tuser,   // [1:0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [olid_pkg::ODATA_W-1:0]  out_tdata,  // [31:0] removed_value, [36:32] count
  output logic [1:0]                    out_tuser   // [1:0] status
);
  import olid_pkg::*;

  mem_req_t                mem_req;
  logic signed [VAL_W-1:0] rd_data;
  res_t                    res;
  logic                    res_valid, res_ready;
  logic                    out_tvalid_r;
  res_t                    out_res_r;

  olid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_mode  (mode_t'(in_tuser)),
    .req_value (in_tdata),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  olid_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {(ODATA_W - VAL_W - CNT_W)'(0), out_res_r.count, out_res_r.removed};

endmodule

[sv/olid_store.sv]
// Entry store: one write port, one registered read port.
// Depends on olid_pkg.
module olid_store (
  input  logic                            clk,
  input  olid_pkg::mem_req_t              req,
  output logic signed [olid_pkg::VAL_W-1:0] rd_data
);
  import olid_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

[sv/olid_ctrl.sv]
// Sequencer for the list: ring pointers, search and compaction loop
// around the single store read port and one equality compare. Depends on olid_pkg.
module olid_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  olid_pkg::mode_t                   req_mode,
  input  logic signed [olid_pkg::VAL_W-1:0] req_value,
  output olid_pkg::mem_req_t                mem_req,
  input  logic signed [olid_pkg::VAL_W-1:0] rd_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output olid_pkg::res_t                    res
);
  import olid_pkg::*;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  mode_t                   mode_r, mode_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] removed_r, removed_nxt;
  logic [CNT_W:0]          pos_p1, pos_p2;
  logic [IDX_W-1:0]        slot;

  assign pos_p1 = {1'b0, pos_r} + (CNT_W+1)'(1);
  assign pos_p2 = {1'b0, pos_r} + (CNT_W+1)'(2);
  assign slot   = front_r + pos_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot;
    mem_req.wdata = rd_data;
    mem_req.raddr = slot;
    req_ready     = 1'b0;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          mode_nxt    = req_mode;
          key_nxt     = req_value;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          pos_nxt     = '0;
          state_nxt   = S_DONE;
          if (req_mode == MODE_INSERT) begin
            if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              front_nxt     = front_r - IDX_W'(1);
              mem_req.we    = 1'b1;
              mem_req.waddr = front_r - IDX_W'(1);
              mem_req.wdata = req_value;
              count_nxt     = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            if (req_mode == MODE_DEL_TAIL) begin
              pos_nxt = count_r - CNT_W'(1);
            end
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        // address already on the read port; data arrives next cycle
        state_nxt = S_CMP;
      end

      S_CMP: begin
        case (mode_r)
          MODE_DEL_HEAD: begin
            removed_nxt = rd_data;
            front_nxt   = front_r + IDX_W'(1);
            count_nxt   = count_r - CNT_W'(1);
            state_nxt   = S_DONE;
          end
          MODE_DEL_TAIL: begin
            removed_nxt = rd_data;
            count_nxt   = count_r - CNT_W'(1);
            state_nxt   = S_DONE;
          end
          default: begin
            if (rd_data == key_r) begin
              removed_nxt = rd_data;
              if (pos_p1 < {1'b0, count_r}) begin
                state_nxt = S_SH_RD;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_DONE;
              end
            end else if (pos_p1 == {1'b0, count_r}) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = pos_p1[CNT_W-1:0];
              state_nxt = S_READ;
            end
          end
        endcase
      end

      S_SH_RD: begin
        mem_req.raddr = slot + IDX_W'(1);
        state_nxt     = S_SH_WR;
      end

      S_SH_WR: begin
        // close the gap: entry at pos+1 moves down to pos
        mem_req.we = 1'b1;
        pos_nxt    = pos_p1[CNT_W-1:0];
        if (pos_p2 < {1'b0, count_r}) begin
          state_nxt = S_SH_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status  = status_r;
  assign res.removed = removed_r;
  assign res.count   = count_r;

endmodule

[sv/olid_checker.sv]
// Port-level checks for the ordered list block, bound to the top level.
// Depends on olid_pkg.
module olid_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [olid_pkg::ODATA_W-1:0] out_tdata,
  input logic [1:0]                   out_tuser
);
  import olid_pkg::*;

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == '0)
    else $error("removed value not zero on error");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[36:32] == CNT_W'(DEPTH))
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[36:32] == '0)
    else $error("empty reported with entries held");

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (.*);

[tb/sv/tb_ordered_list_insert_delete.sv]
// Self-checking testbench for ordered_list_insert_delete: directed and random
// requests against a queue-based model of the list, checked beat by beat.
// Depends on olid_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  localparam int MAX_REPORTS = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ODATA_W-1:0]  out_tdata;
  logic [1:0]          out_tuser;

  // list contents as the block should hold them, front first
  logic signed [31:0]  list_model[$];
  res_t                awaited_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_granted = 0;
  int hold_left = 0;
  int mismatches = 0;
  int replies_checked = 0;
  int requests_sent = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int deepest_key_hit = 0;

  ordered_list_insert_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the reply to one request and updates the list copy.
  function automatic res_t apply_request(mode_t m, logic signed [31:0] v);
    res_t r;
    int   hit;
    r.status  = ST_OK;
    r.removed = '0;
    hit = -1;
    if (m == MODE_INSERT) begin
      if (list_model.size() >= DEPTH)
        r.status = ST_FULL;
      else
        list_model.push_front(v);
    end else if (list_model.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (m)
        MODE_DEL_HEAD: r.removed = list_model.pop_front();
        MODE_DEL_TAIL: r.removed = list_model.pop_back();
        default: begin
          for (int i = 0; i < list_model.size(); i++)
            if (hit < 0 && list_model[i] == v) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.removed = list_model[hit];
            list_model.delete(hit);
            if (hit > deepest_key_hit) deepest_key_hit = hit;
          end
        end
      endcase
    end
    r.count = CNT_W'(list_model.size());
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // One request beat; valid stays high straight into the next beat when no gap is drawn.
  task automatic send_request(mode_t m, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_replies.push_back(apply_request(m, v));
    requests_sent++;
  endtask

  task automatic wait_replies;
    in_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_value;
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // narrow pool so duplicates and hits are common
        v = $urandom_range(7);
        v = v - 4;
      end
      4: case ($urandom_range(3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        2: v = '0;
        default: v = '1;
      endcase
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver: random ready, or a long hold when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_granted != hold_requests) begin
      hold_granted = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest awaited reply.
  always @(posedge clk) begin : check_beat
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_checked++;
      if (awaited_replies.size() == 0) begin
        flag_error($sformatf("unexpected reply tuser=%0d tdata=%h", out_tuser, out_tdata));
      end else begin
        want = awaited_replies.pop_front();
        if (out_tuser !== want.status)
          flag_error($sformatf("status exp %0d got %0d", want.status, out_tuser));
        if (out_tdata[31:0] !== want.removed)
          flag_error($sformatf("removed_value exp %h got %h", want.removed, out_tdata[31:0]));
        if (out_tdata[36:32] !== want.count)
          flag_error($sformatf("count exp %0d got %0d", want.count, out_tdata[36:32]));
      end
    end
  end

  task automatic test_empty_list;
    send_request(MODE_DEL_HEAD, 32'sd0);
    send_request(MODE_DEL_TAIL, 32'sd0);
    send_request(MODE_DEL_KEY, 32'sh7FFF_FFFF);
  endtask

  // Sixteen inserts with extremes and a repeated value, then one into the full store.
  task automatic test_fill_and_overflow;
    logic signed [31:0] fill_vals[16];
    fill_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                  32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_1234, 32'sd7,
                  32'sh0000_1234, -32'sd8, 32'sh0F0F_0F0F, 32'shF0F0_F0F0,
                  32'sd1, 32'sh0000_1234, 32'sh4000_0000, 32'shC000_0001};
    foreach (fill_vals[i]) send_request(MODE_INSERT, fill_vals[i]);
    send_request(MODE_INSERT, 32'sh1357_9BDF);
  endtask

  task automatic test_delete_kinds;
    send_request(MODE_DEL_KEY, 32'sh1357_9BDF);   // not present
    send_request(MODE_DEL_KEY, 32'sh0000_1234);   // duplicate: front one goes
    send_request(MODE_DEL_HEAD, 32'sd0);
    send_request(MODE_DEL_TAIL, 32'sd0);
    send_request(MODE_DEL_KEY, 32'sh7FFF_FFFF);   // entry at the back
  endtask

  // Receiver holds off while the sender keeps offering back-to-back beats.
  task automatic test_output_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 12; i++)
      send_request((i % 3 == 0) ? MODE_DEL_KEY : MODE_INSERT, random_value());
    wait_replies();
  endtask

  // Insert-heavy and delete-heavy stretches alternate so the list swings
  // between empty and full; keys are mostly taken from the list.
  task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
    mode_t              m;
    logic signed [31:0] v;
    int                 insert_pct;
    int                 pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    insert_pct = 75;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 39) insert_pct = 100 - insert_pct;
      if ($urandom_range(99) < 5) begin
        m = mode_t'($urandom_range(3));
        v = $urandom;
      end else if ($urandom_range(99) < insert_pct) begin
        m = MODE_INSERT;
        v = random_value();
      end else begin
        pick = $urandom_range(99);
        v = random_value();
        if (pick < 40) begin
          m = MODE_DEL_KEY;
          if (list_model.size() > 0 && $urandom_range(9) < 8)
            v = list_model[$urandom_range(list_model.size() - 1)];
        end else if (pick < 70) begin
          m = MODE_DEL_HEAD;
        end else begin
          m = MODE_DEL_TAIL;
        end
      end
      send_request(m, v);
    end
    wait_replies();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_and_overflow();
    test_delete_kinds();
    wait_replies();
    test_output_backpressure();
    test_random_traffic(600, 37, 51);
    test_random_traffic(600, 51, 37);
    test_random_traffic(600, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_replies.size() != 0)
      flag_error($sformatf("%0d replies never arrived", awaited_replies.size()));
    $display("Sent %0d requests, checked %0d replies (%0d mismatches).",
             requests_sent, replies_checked, mismatches);
    $display("Replies: ok %0d, empty %0d, not found %0d, full %0d; deepest key hit at %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], deepest_key_hit);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: %0d replies still awaited", awaited_replies.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
